// File: rtl/core/ttce_pkg.sv
// Shared types, constants and widths of the text terminal character engine.
package ttce_pkg;

    // Default screen geometry
    localparam int TTC_COLUMNS = 80;
    localparam int TTC_ROWS    = 25;

    // Fixed field widths at the ports
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int POS_W  = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;

    // Depth of the command queue between front and back (power of two)
    localparam int CMD_DEPTH = 4;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_BS       = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_LO = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'h7F;

    // Cell and attribute reset values
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // Command classes decided by the front
    typedef enum logic [2:0] {
        OP_IGNORE,
        OP_BACK,
        OP_RETURN,
        OP_FEED,
        OP_PRINT
    } t_op;

    // One queued command
    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] char_code;
    } t_cmd;

    // One result
    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic              cell_written;
        logic [POS_W-1:0]  cell_address;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } t_res;

    // Back stage sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_BLANK
    } t_state;

endpackage

// File: rtl/core/ttce_front.sv
// Front stage: accepts character requests, classifies them and queues commands.
module ttce_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [ttce_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                         i_clearing,
    output logic                         o_cmd_valid,
    output ttce_pkg::t_cmd               o_cmd,
    input  logic                         i_cmd_take
);
    import ttce_pkg::*;

    localparam int PW = $clog2(CMD_DEPTH);

    t_cmd            r_queue [CMD_DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [PW:0]     r_count, n_count;
    logic            accept;
    logic            take;
    t_cmd            cmd_in;

    // Classify the incoming byte
    always_comb begin
        cmd_in.char_code = i_char_code;
        if (i_char_code == CHAR_BS) begin
            cmd_in.op = OP_BACK;
        end else if (i_char_code == CHAR_CR) begin
            cmd_in.op = OP_RETURN;
        end else if (i_char_code == CHAR_LF) begin
            cmd_in.op = OP_FEED;
        end else if (i_char_code >= CHAR_PRINT_LO && i_char_code <= CHAR_PRINT_HI) begin
            cmd_in.op = OP_PRINT;
        end else begin
            cmd_in.op = OP_IGNORE;
        end
    end

    // Hold off requests while the queue is full or the screen is being cleared
    assign full        = (r_count == (PW+1)'(CMD_DEPTH)) || i_clearing;
    assign accept      = push && !full;
    assign o_cmd_valid = (r_count != '0);
    assign take        = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_queue[r_rptr];

    // Advance pointers and count
    always_comb begin
        n_wptr  = accept ? r_wptr + PW'(1) : r_wptr;
        n_rptr  = take ? r_rptr + PW'(1) : r_rptr;
        n_count = r_count;
        if (accept && !take) begin
            n_count = r_count + (PW+1)'(1);
        end else if (take && !accept) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the command
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_queue[r_wptr] <= cmd_in;
        end
    end

endmodule

// File: rtl/core/ttce_back.sv
// Back stage: cursor update, screen store with row rotation, result register.
module ttce_back #(
    parameter int COLUMNS = ttce_pkg::TTC_COLUMNS,
    parameter int ROWS    = ttce_pkg::TTC_ROWS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ttce_pkg::ATTR_W-1:0]  i_text_attr,
    input  logic                         i_cmd_valid,
    input  ttce_pkg::t_cmd               i_cmd,
    output logic                         o_cmd_take,
    output logic                         o_clearing,
    output logic                         o_res_valid,
    output ttce_pkg::t_res               o_res,
    input  logic                         i_res_pop
);
    import ttce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [RW-1:0]       r_base, n_base;
    logic [RW-1:0]       r_blank_row, n_blank_row;
    logic [AW-1:0]       r_sweep, n_sweep;
    t_res                r_res, n_res;
    logic                r_res_full, n_res_full;
    logic [CELL_W-1:0]   r_screen [CELLS];

    logic                sweep_end;
    logic                slot_free;
    logic [CW:0]         col_inc;
    logic [CW:0]         step_col;
    logic [RW:0]         step_row;
    logic                scroll;
    logic [RW-1:0]       fin_row;
    logic [CW-1:0]       fin_col;
    logic [AW-1:0]       pos_aw;
    logic [AW-1:0]       wr_logic_aw;
    logic [RW:0]         phys_sum;
    logic [RW-1:0]       phys_row;
    logic [RW-1:0]       base_inc;
    logic [31:0]         pos_ext;
    logic [31:0]         col_ext;
    logic [31:0]         row_ext;
    logic [31:0]         addr_ext;
    logic [CELL_W-1:0]   print_cell;
    logic                mem_we;
    logic [AW-1:0]       mem_addr;
    logic [CELL_W-1:0]   mem_data;
    logic                is_print;

    assign slot_free = !r_res_full || i_res_pop;
    assign is_print  = (i_cmd.op == OP_PRINT);
    assign sweep_end = (r_state == ST_CLEAR) ? (r_sweep == AW'(CELLS - 1))
                                              : (r_sweep == AW'(COLUMNS - 1));

    // Step the cursor for the queued command
    always_comb begin
        col_inc  = {1'b0, r_col} + (CW+1)'(1);
        step_col = {1'b0, r_col};
        step_row = {1'b0, r_row};
        case (i_cmd.op)
            OP_BACK: begin
                if (r_col != '0) begin
                    step_col = {1'b0, r_col} - (CW+1)'(1);
                end
            end
            OP_RETURN: begin
                step_col = '0;
            end
            OP_FEED: begin
                step_col = '0;
                step_row = {1'b0, r_row} + (RW+1)'(1);
            end
            OP_PRINT: begin
                if (col_inc >= (CW+1)'(COLUMNS)) begin
                    step_col = '0;
                    step_row = {1'b0, r_row} + (RW+1)'(1);
                end else begin
                    step_col = col_inc;
                end
            end
            default: begin
                step_col = {1'b0, r_col};
            end
        endcase
        scroll  = (step_row >= (RW+1)'(ROWS));
        fin_row = scroll ? RW'(ROWS - 1) : step_row[RW-1:0];
        fin_col = step_col[CW-1:0];
    end

    // Linear positions, logical and in the rotated store
    always_comb begin
        pos_aw      = AW'(fin_row) * AW'(COLUMNS) + AW'(fin_col);
        wr_logic_aw = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
        phys_sum    = {1'b0, r_row} + {1'b0, r_base};
        phys_row    = (phys_sum >= (RW+1)'(ROWS)) ? RW'(phys_sum - (RW+1)'(ROWS))
                                                   : phys_sum[RW-1:0];
        base_inc    = (r_base == RW'(ROWS - 1)) ? '0 : r_base + RW'(1);
        pos_ext     = 32'(pos_aw);
        col_ext     = 32'(fin_col);
        row_ext     = 32'(fin_row);
        addr_ext    = 32'(wr_logic_aw);
        print_cell  = {i_text_attr, i_cmd.char_code};
    end

    // Pick the next sequencer state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (sweep_end) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_cmd_valid && slot_free && scroll) begin
                    n_state = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (sweep_end) begin
                    n_state = ST_RUN;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Drive take and the store write port
    always_comb begin
        o_cmd_take = 1'b0;
        o_clearing = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = r_sweep;
        mem_data   = BLANK_CELL;
        case (r_state)
            ST_CLEAR: begin
                o_clearing = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = r_sweep;
            end
            ST_RUN: begin
                o_cmd_take = i_cmd_valid && slot_free;
                mem_we     = o_cmd_take && is_print;
                mem_addr   = AW'(phys_row) * AW'(COLUMNS) + AW'(r_col);
                mem_data   = print_cell;
            end
            ST_BLANK: begin
                mem_we   = 1'b1;
                mem_addr = AW'(r_blank_row) * AW'(COLUMNS) + r_sweep;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Update cursor, rotation, sweep counter and result
    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_base      = r_base;
        n_blank_row = r_blank_row;
        n_sweep     = (r_state != ST_RUN && !sweep_end) ? r_sweep + AW'(1) : '0;
        n_res       = r_res;
        n_res_full  = r_res_full;
        if (i_res_pop && r_res_full) begin
            n_res_full = 1'b0;
        end
        if (o_cmd_take) begin
            n_col                 = fin_col;
            n_row                 = fin_row;
            n_res_full            = 1'b1;
            n_res.cursor_position = pos_ext[POS_W-1:0];
            n_res.cursor_column   = col_ext[COL_W-1:0];
            n_res.cursor_row      = row_ext[ROW_W-1:0];
            n_res.cell_written    = is_print;
            n_res.cell_address    = is_print ? addr_ext[POS_W-1:0] : '0;
            n_res.cell_value      = is_print ? print_cell : '0;
            n_res.scrolled        = scroll;
            if (scroll) begin
                n_base      = base_inc;
                n_blank_row = r_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_col      <= '0;
            r_row      <= '0;
            r_base     <= '0;
            r_sweep    <= '0;
            r_res_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_base     <= n_base;
            r_sweep    <= n_sweep;
            r_res_full <= n_res_full;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_blank_row <= n_blank_row;
        r_res       <= n_res;
    end

    // Write the screen store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_addr] <= mem_data;
        end
    end

    assign o_res_valid = r_res_full;
    assign o_res       = r_res;

endmodule

// File: rtl/core/text_terminal_character_engine.sv
// Top level of the text terminal character engine: config register, front and back.
//
//  channel   direction  handshake                  payload
//  input     in         push / full                i_char_code
//  result    out        empty / pop                o_cursor_* , o_cell_*, o_scrolled
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_text_attribute
//
// The back stage carries out one queued character per cycle while the result slot is
// free; a request passes through the command queue and then the result register.
// A scroll rotates the row base and blanks the new bottom line, one store write per cell,
// while the next character waits in the command queue. After reset a clearing pass
// fills every cell of the store with a blank cell; full stays high until the pass ends.
// Config writes are always taken.
module text_terminal_character_engine #(
    parameter int COLUMNS = ttce_pkg::TTC_COLUMNS,
    parameter int ROWS    = ttce_pkg::TTC_ROWS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [ttce_pkg::CHAR_W-1:0]  i_char_code,
    output logic                         empty,
    input  logic                         pop,
    output logic [ttce_pkg::POS_W-1:0]   o_cursor_position,
    output logic [ttce_pkg::COL_W-1:0]   o_cursor_column,
    output logic [ttce_pkg::ROW_W-1:0]   o_cursor_row,
    output logic                         o_cell_written,
    output logic [ttce_pkg::POS_W-1:0]   o_cell_address,
    output logic [ttce_pkg::CELL_W-1:0]  o_cell_value,
    output logic                         o_scrolled,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [ttce_pkg::ATTR_W-1:0]  i_cfg_text_attribute
);
    import ttce_pkg::*;

    logic [ATTR_W-1:0] r_text_attr;
    logic              cmd_valid;
    t_cmd              cmd;
    logic              cmd_take;
    logic              clearing;
    logic              res_valid;
    t_res              res;

    // Take config writes at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= ATTR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_text_attr <= i_cfg_text_attribute;
        end
    end

    ttce_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char_code (i_char_code),
        .i_clearing  (clearing),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    ttce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text_attr (r_text_attr),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_clearing  (clearing),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    // Present the oldest result
    assign empty             = !res_valid;
    assign o_cursor_position = res.cursor_position;
    assign o_cursor_column   = res.cursor_column;
    assign o_cursor_row      = res.cursor_row;
    assign o_cell_written    = res.cell_written;
    assign o_cell_address    = res.cell_address;
    assign o_cell_value      = res.cell_value;
    assign o_scrolled        = res.scrolled;

endmodule
